### sv/grc_pkg.sv
// ----------------------------------------------------------------------------
// grc_pkg
// Shared types and constants for the graph reachability closure block.
// ----------------------------------------------------------------------------
package grc_pkg;

  localparam int ID_W = 6;
  localparam int BC_W = 7;
  localparam logic [BC_W-1:0] BC_RESET = 7'd64;

  typedef enum logic [1:0] {
    KIND_EDGE  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_EXEC  = 7'b0000010,
    ST_K_RD  = 7'b0000100,
    ST_K_LAT = 7'b0001000,
    ST_SCAN  = 7'b0010000,
    ST_Q_RD  = 7'b0100000,
    ST_SPARE = 7'b1000000
  } state_t;

endpackage

### sv/graph_reachability_closure.sv
// ----------------------------------------------------------------------------
// graph_reachability_closure
// Edge store and reachability queries over a bit-row transitive closure.
// ----------------------------------------------------------------------------
// Edge, clear and out-of-range items: the row is read as the item is taken and
// the result registered from execute, which waits while the output is held; no
// new item is taken until then. Query on a current closure: the same. Query
// after a change first rebuilds the closure in the row memory (K_RD, K_LAT and
// SCAN per pivot row, then Q_RD). Reset is synchronous; the graph clears at
// once via per-row valid bits, no clearing pass, block_count returns to 64.
// ----------------------------------------------------------------------------
module graph_reachability_closure #(
  parameter int MAX_BLOCKS = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               kind,
  input  logic [grc_pkg::ID_W-1:0] from_block,
  input  logic [grc_pkg::ID_W-1:0] to_block,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     reachable,
  output logic                     out_of_range,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [grc_pkg::BC_W-1:0] cfg_data
);

  localparam int IW     = $clog2(MAX_BLOCKS);
  localparam int CW_RAW = $clog2(MAX_BLOCKS + 1);
  localparam int CW     = (CW_RAW > grc_pkg::BC_W) ? CW_RAW : grc_pkg::BC_W;

  grc_pkg::state_t state, state_next;
  grc_pkg::kind_t  kind_q;

  logic [grc_pkg::BC_W-1:0] block_count;
  logic [CW-1:0]            bc_ext, act, last_idx;
  logic                     closure_valid;
  logic [MAX_BLOCKS-1:0]    row_valid;

  // row memory: one row of ancestor bits per node, closed under paths after a rebuild
  logic [MAX_BLOCKS-1:0] rows [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] mem_q, rd_row, wr_data, row_k;
  logic                  rd_vld_q, rd_en, wr_en;
  logic [IW-1:0]         rd_addr, wr_addr;

  logic [IW-1:0] from_q, to_q, k_idx, b_idx;
  logic          bad_q, bad_in;
  logic          in_acc, cfg_acc, out_free;
  logic          k_last, b_last;
  logic          res_load, res_reach, res_oor, clr_graph, edge_done;

  assign bc_ext   = CW'(block_count);
  assign act      = (bc_ext > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : bc_ext;
  assign last_idx = act - CW'(1);
  assign bad_in   = (CW'(from_block) >= act) || (CW'(to_block) >= act);
  assign k_last   = (CW'(k_idx) == last_idx);
  assign b_last   = (CW'(b_idx) == last_idx);

  assign in_ready  = (state == grc_pkg::ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state == grc_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_free  = !out_valid || out_ready;

  assign rd_row = rd_vld_q ? mem_q : '0;

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = to_q;
    wr_en      = 1'b0;
    wr_addr    = to_q;
    wr_data    = rd_row | (MAX_BLOCKS'(1) << from_q);
    res_load   = 1'b0;
    res_reach  = 1'b0;
    res_oor    = 1'b0;
    clr_graph  = 1'b0;
    edge_done  = 1'b0;
    unique case (state)
      grc_pkg::ST_IDLE: begin
        if (in_acc) begin
          rd_en      = 1'b1;
          rd_addr    = IW'(to_block);
          state_next = grc_pkg::ST_EXEC;
        end
      end
      grc_pkg::ST_EXEC: begin
        priority if (kind_q == grc_pkg::KIND_NONE) begin
          state_next = grc_pkg::ST_IDLE;
        end else if (kind_q == grc_pkg::KIND_QUERY && !bad_q && !closure_valid) begin
          state_next = grc_pkg::ST_K_RD;
        end else if (out_free) begin
          res_load   = 1'b1;
          state_next = grc_pkg::ST_IDLE;
          priority if (kind_q == grc_pkg::KIND_CLEAR) begin
            clr_graph = 1'b1;
          end else if (bad_q) begin
            res_oor = 1'b1;
          end else if (kind_q == grc_pkg::KIND_EDGE) begin
            wr_en     = 1'b1;
            edge_done = 1'b1;
          end else begin
            res_reach = rd_row[from_q];
          end
        end
      end
      grc_pkg::ST_K_RD: begin
        rd_en      = 1'b1;
        rd_addr    = k_idx;
        state_next = grc_pkg::ST_K_LAT;
      end
      grc_pkg::ST_K_LAT: begin
        rd_en      = 1'b1;
        rd_addr    = '0;
        state_next = grc_pkg::ST_SCAN;
      end
      grc_pkg::ST_SCAN: begin
        // row b takes in row k when k is an ancestor of b
        wr_en   = rd_row[k_idx];
        wr_addr = b_idx;
        wr_data = rd_row | row_k;
        if (!b_last) begin
          rd_en   = 1'b1;
          rd_addr = b_idx + IW'(1);
        end else if (k_last) begin
          state_next = grc_pkg::ST_Q_RD;
        end else begin
          state_next = grc_pkg::ST_K_RD;
        end
      end
      grc_pkg::ST_Q_RD: begin
        rd_en      = 1'b1;
        rd_addr    = to_q;
        state_next = grc_pkg::ST_EXEC;
      end
      default: begin
        state_next = grc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rows[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q    <= rows[rd_addr];
      rd_vld_q <= row_valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= grc_pkg::ST_IDLE;
      block_count   <= grc_pkg::BC_RESET;
      closure_valid <= 1'b0;
      row_valid     <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_acc) begin
        block_count <= cfg_data;
      end
      if (cfg_acc || clr_graph) begin
        row_valid     <= '0;
        closure_valid <= 1'b0;
      end else begin
        if (wr_en) begin
          row_valid[wr_addr] <= 1'b1;
        end
        if (edge_done) begin
          closure_valid <= 1'b0;
        end else if (state == grc_pkg::ST_Q_RD) begin
          closure_valid <= 1'b1;
        end
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_q <= grc_pkg::kind_t'(kind);
      from_q <= IW'(from_block);
      to_q   <= IW'(to_block);
      bad_q  <= bad_in;
    end
    if (res_load) begin
      reachable    <= res_reach;
      out_of_range <= res_oor;
    end
    if (state == grc_pkg::ST_EXEC) begin
      k_idx <= '0;
    end
    if (state == grc_pkg::ST_K_LAT) begin
      row_k <= rd_row;
      b_idx <= '0;
    end
    if (state == grc_pkg::ST_SCAN) begin
      if (!b_last) begin
        b_idx <= b_idx + IW'(1);
      end else if (!k_last) begin
        k_idx <= k_idx + IW'(1);
      end
    end
  end

  a_new_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == grc_pkg::ST_EXEC))
    else $error("result raised outside execute");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write of one row in the same cycle");

  a_clear_empties_rows: assert property (@(posedge clk) disable iff (rst)
    clr_graph |=> (row_valid == '0))
    else $error("rows still valid after a clear");

  a_oor_not_reachable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_of_range) |-> !reachable)
    else $error("out-of-range item reported reachable");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == grc_pkg::ST_SCAN) |-> ((CW'(b_idx) < act) && (CW'(k_idx) < act)))
    else $error("closure scan beyond active node count");

endmodule

### tb/graph_reachability_closure_tb.sv
// ----------------------------------------------------------------------------
// graph_reachability_closure_tb
// Self-checking bench for the reachability closure block. A short table of
// directed items comes first: reset state, extreme node ids, cycles, self
// loops, clears and out-of-range ids. Random phases follow, each under its own
// block_count, including zero and values above the node limit. Each result
// is checked in order against the table's verdict or a bit-row model of the
// predecessor and reach matrices. Both handshakes stall at random, and the
// receiver holds off once for a long stretch while items keep coming.
// ----------------------------------------------------------------------------
module graph_reachability_closure_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES        = 64;
  localparam int LIMIT        = 2_000_000;
  localparam int DRAIN_CYCLES = 16;
  localparam int SQUEEZE_LEN  = 600;
  localparam int PHASE_ITEMS  = 96;
  localparam int NUM_PHASES   = 14;
  localparam int NUM_FIXED    = 11;
  localparam int NUM_DIR      = 27;

  typedef struct packed {
    logic reachable;
    logic out_of_range;
  } verdict_t;

  typedef struct packed {
    logic       cfg;
    logic [6:0] bc;
    logic [1:0] k;
    logic [5:0] f;
    logic [5:0] t;
    logic       typed;
    logic       rch;
    logic       oor;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{1'b0, 7'd0, grc_pkg::KIND_QUERY, 6'd0,  6'd0,  1'b1, 1'b0, 1'b0},
    '{1'b0, 7'd0, grc_pkg::KIND_QUERY, 6'd63, 6'd63, 1'b1, 1'b0, 1'b0},
    '{1'b0, 7'd0, grc_pkg::KIND_EDGE,  6'd0,  6'd63, 1'b1, 1'b0, 1'b0},
    '{1'b0, 7'd0, grc_pkg::KIND_QUERY, 6'd0,  6'd63, 1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0, grc_pkg::KIND_QUERY, 6'd63, 6'd0,  1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0, grc_pkg::KIND_EDGE,  6'd63, 6'd0,  1'b1, 1'b0, 1'b0},
    '{1'b0, 7'd0, grc_pkg::KIND_QUERY, 6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0, grc_pkg::KIND_QUERY, 6'd63, 6'd63, 1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0, grc_pkg::KIND_NONE,  6'd21, 6'd42, 1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0, grc_pkg::KIND_CLEAR, 6'd63, 6'd63, 1'b1, 1'b0, 1'b0},
    '{1'b0, 7'd0, grc_pkg::KIND_QUERY, 6'd0,  6'd63, 1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0, grc_pkg::KIND_EDGE,  6'd42, 6'd21, 1'b1, 1'b0, 1'b0},
    '{1'b0, 7'd0, grc_pkg::KIND_EDGE,  6'd21, 6'd42, 1'b1, 1'b0, 1'b0},
    '{1'b0, 7'd0, grc_pkg::KIND_QUERY, 6'd42, 6'd42, 1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0, grc_pkg::KIND_EDGE,  6'd5,  6'd5,  1'b1, 1'b0, 1'b0},
    '{1'b0, 7'd0, grc_pkg::KIND_QUERY, 6'd5,  6'd5,  1'b0, 1'b0, 1'b0},
    '{1'b1, 7'd4, grc_pkg::KIND_NONE,  6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0, grc_pkg::KIND_EDGE,  6'd4,  6'd0,  1'b1, 1'b0, 1'b1},
    '{1'b0, 7'd0, grc_pkg::KIND_EDGE,  6'd0,  6'd63, 1'b1, 1'b0, 1'b1},
    '{1'b0, 7'd0, grc_pkg::KIND_QUERY, 6'd63, 6'd63, 1'b1, 1'b0, 1'b1},
    '{1'b0, 7'd0, grc_pkg::KIND_EDGE,  6'd1,  6'd2,  1'b1, 1'b0, 1'b0},
    '{1'b0, 7'd0, grc_pkg::KIND_EDGE,  6'd2,  6'd3,  1'b1, 1'b0, 1'b0},
    '{1'b0, 7'd0, grc_pkg::KIND_QUERY, 6'd1,  6'd3,  1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0, grc_pkg::KIND_QUERY, 6'd3,  6'd1,  1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0, grc_pkg::KIND_CLEAR, 6'd63, 6'd0,  1'b1, 1'b0, 1'b0},
    '{1'b0, 7'd0, grc_pkg::KIND_NONE,  6'd63, 6'd63, 1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0, grc_pkg::KIND_QUERY, 6'd1,  6'd3,  1'b0, 1'b0, 1'b0}
  };

  localparam logic [6:0] PHASE_BC [NUM_FIXED] = '{
    7'd1, 7'd64, 7'd0, 7'd2, 7'd9, 7'd127, 7'd5, 7'd100, 7'd3, 7'd12, 7'd16
  };

  logic                     clk          = 1'b0;
  logic                     rst          = 1'b1;
  logic                     in_valid     = 1'b0;
  logic                     in_ready;
  logic [1:0]               kind         = grc_pkg::KIND_NONE;
  logic [grc_pkg::ID_W-1:0] from_block   = '0;
  logic [grc_pkg::ID_W-1:0] to_block     = '0;
  logic                     out_valid;
  logic                     out_ready    = 1'b0;
  logic                     reachable;
  logic                     out_of_range;
  logic                     cfg_valid    = 1'b0;
  logic                     cfg_ready;
  logic [grc_pkg::BC_W-1:0] cfg_data     = '0;

  // model of the graph
  logic [NODES-1:0]         pred_m  [NODES];
  logic [NODES-1:0]         reach_m [NODES];
  bit                       closure_ok;
  logic [grc_pkg::BC_W-1:0] node_limit;

  verdict_t expected_verdicts [$];
  verdict_t due;
  int       mismatches    = 0;
  int       cycle_count   = 0;
  int       stall_left    = 0;
  bit       calm          = 1'b0;
  bit       squeeze_req   = 1'b0;
  bit       squeeze_done  = 1'b0;

  graph_reachability_closure dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .from_block   (from_block),
    .to_block     (to_block),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .reachable    (reachable),
    .out_of_range (out_of_range),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic int live_nodes();
    return (node_limit > NODES) ? NODES : int'(node_limit);
  endfunction

  function automatic void wipe_graph();
    for (int i = 0; i < NODES; i++) begin
      pred_m[i]  = '0;
      reach_m[i] = '0;
    end
    closure_ok = 1'b0;
  endfunction

  function automatic void rebuild_reach();
    int               n;
    bit               changed;
    logic [NODES-1:0] nxt;
    n = live_nodes();
    for (int i = 0; i < NODES; i++) reach_m[i] = '0;
    do begin
      changed = 1'b0;
      for (int b = 0; b < n; b++) begin
        for (int p = 0; p < n; p++) begin
          if (pred_m[b][p]) begin
            nxt    = reach_m[b] | reach_m[p];
            nxt[p] = 1'b1;
            if (nxt != reach_m[b]) begin
              reach_m[b] = nxt;
              changed    = 1'b1;
            end
          end
        end
      end
    end while (changed);
    closure_ok = 1'b1;
  endfunction

  function automatic void apply_item(input grc_pkg::kind_t k, input logic [5:0] f,
                                     input logic [5:0] t,
                                     output bit has, output verdict_t v);
    int n;
    bit bad;
    n   = live_nodes();
    bad = (int'(f) >= n) || (int'(t) >= n);
    v   = '0;
    has = 1'b1;
    case (k)
      grc_pkg::KIND_NONE: begin
        has = 1'b0;
      end
      grc_pkg::KIND_CLEAR: begin
        wipe_graph();
      end
      grc_pkg::KIND_EDGE: begin
        if (bad) begin
          v.out_of_range = 1'b1;
        end else begin
          pred_m[t][f] = 1'b1;
          closure_ok   = 1'b0;
        end
      end
      default: begin
        if (bad) begin
          v.out_of_range = 1'b1;
        end else begin
          if (!closure_ok) rebuild_reach();
          v.reachable = reach_m[t][f];
        end
      end
    endcase
  endfunction

  function automatic logic [5:0] pick_node(int lo, int span);
    if (span <= 0) return 6'($urandom_range(0, 63));
    return 6'(lo + $urandom_range(0, span - 1));
  endfunction

  task automatic offer_item(input grc_pkg::kind_t k, input logic [5:0] f,
                            input logic [5:0] t,
                            input bit typed, input verdict_t typed_v);
    bit       has;
    verdict_t v;
    while (!calm && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    from_block <= f;
    to_block   <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_item(k, f, t, has, v);
    if (has) expected_verdicts = {expected_verdicts, (typed ? typed_v : v)};
  endtask

  task automatic write_block_count(input logic [grc_pkg::BC_W-1:0] v);
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    node_limit = v;
    wipe_graph();
  endtask

  // result checking and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          $error("unexpected result: reachable %0b out_of_range %0b", reachable, out_of_range);
          mismatches++;
        end else begin
          due = expected_verdicts.pop_front();
          if (reachable !== due.reachable) begin
            $error("reachable: expected %0b, got %0b", due.reachable, reachable);
            mismatches++;
          end
          if (out_of_range !== due.out_of_range) begin
            $error("out_of_range: expected %0b, got %0b", due.out_of_range, out_of_range);
            mismatches++;
          end
        end
      end
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        stall_left   = SQUEEZE_LEN;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 27);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("graph_reachability_closure: mismatch");
      $finish;
    end
  end

  initial begin
    int             nact;
    int             results;
    int             batch_left;
    int             win;
    int             base;
    int             r;
    int             sel;
    bit             big_graph;
    bit             qbatch;
    grc_pkg::kind_t k;
    logic [5:0]     f;
    logic [5:0]     t;
    logic [6:0]     bc;
    dir_row_t       row;
    verdict_t       tv;

    node_limit = grc_pkg::BC_RESET;
    wipe_graph();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NUM_DIR; i++) begin
      row = DIR_ROWS[i];
      if (row.cfg) begin
        write_block_count(row.bc);
      end else begin
        tv = '{reachable: row.rch, out_of_range: row.oor};
        offer_item(grc_pkg::kind_t'(row.k), row.f, row.t, row.typed, tv);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      bc = (p < NUM_FIXED) ? PHASE_BC[p] : 7'($urandom_range(3, 16));
      write_block_count(bc);
      calm <= (p == 6);
      if (p == 4) squeeze_req <= 1'b1;
      nact       = live_nodes();
      big_graph  = nact > 16;
      results    = 0;
      batch_left = 0;
      qbatch     = 1'b1;
      win        = nact;
      base       = 0;
      while (results < PHASE_ITEMS) begin
        // big graphs: batches of edges then batches of queries, one rebuild each
        if (big_graph) begin
          if (batch_left == 0) begin
            qbatch     = !qbatch;
            batch_left = qbatch ? $urandom_range(4, 12) : $urandom_range(8, 24);
            win        = $urandom_range(4, 14);
            base       = $urandom_range(0, nact - win);
          end
          batch_left--;
        end
        r = $urandom_range(0, 99);
        f = pick_node(base, win);
        t = pick_node(base, win);
        if (big_graph && $urandom_range(0, 9) == 0) f = pick_node(0, nact);
        if (r < 4) begin
          k = grc_pkg::KIND_NONE;
          f = 6'($urandom_range(0, 63));
          t = 6'($urandom_range(0, 63));
        end else if (r < 12 && nact < NODES) begin
          k   = (r < 8) ? grc_pkg::KIND_EDGE : grc_pkg::KIND_QUERY;
          sel = $urandom_range(0, 2);
          if (sel != 1) f = 6'($urandom_range(nact, 63));
          if (sel != 0) t = 6'($urandom_range(nact, 63));
        end else if (r < 15 && !(big_graph && qbatch)) begin
          k = grc_pkg::KIND_CLEAR;
          if ($urandom_range(0, 1)) f = 6'($urandom_range(0, 63));
        end else if (big_graph) begin
          k = qbatch ? grc_pkg::KIND_QUERY : grc_pkg::KIND_EDGE;
        end else begin
          k = ($urandom_range(0, 99) < 50) ? grc_pkg::KIND_EDGE : grc_pkg::KIND_QUERY;
        end
        offer_item(k, f, t, 1'b0, '0);
        if (k != grc_pkg::KIND_NONE) results++;
      end
      in_valid <= 1'b0;
      calm     <= 1'b0;
    end

    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("graph_reachability_closure: match");
    end else begin
      $display("graph_reachability_closure: mismatch");
    end
    $finish;
  end

endmodule

### graph_reachability_closure.f
sv/grc_pkg.sv
sv/graph_reachability_closure.sv
tb/graph_reachability_closure_tb.sv
